// ===== src/kvt_pkg.sv =====
// Shared constants, codes and types of the compacting key/value table.
`default_nettype none

package kvt_pkg;

  localparam int CAPACITY    = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam int FIELD_W  = 32;
  localparam int ID_W     = 4;
  localparam int FID_W    = 4;
  localparam int TOTAL_W  = 5;
  localparam int CMP_W    = (CNT_W > ID_W) ? CNT_W : ID_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD     = 3'd0,
    KIND_DEL_ID  = 3'd1,
    KIND_DEL_KEY = 3'd2,
    KIND_GET_KEY = 3'd3,
    KIND_GET_ID  = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_DUP   = 3'd1,
    STAT_NOKEY = 3'd2,
    STAT_RANGE = 3'd3,
    STAT_FULL  = 3'd4
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  typedef struct packed {
    logic                   active;
    logic [KIND_W-1:0]      kind;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
    logic [ID_W-1:0]        id;
    logic [CNT_W-1:0]       count;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/compacting_key_value_table.sv =====
// Top level of the compacting key/value table: command capture, cell row and result register.
`default_nettype none

// A transaction is taken when start is high and busy is low; busy then stays high for
// one cycle while every cell compares its key in parallel and the row shifts, appends
// or reads. The result is registered from that busy cycle and appears on the outputs
// with strobe_o high for exactly one cycle. A new transaction may be started in that
// same cycle, since busy is low again; none is taken while busy is high, so each one
// passes the capture step and the compare-and-update step of the cell row in turn.
// Results cannot be held off and must be taken in the strobe cycle. Entries beyond the
// current count are never observed, so no clearing pass follows reset.
module compacting_key_value_table
  import kvt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KIND_W-1:0]   kind_i,
  input  wire logic [FIELD_W-1:0]  item_key_i,
  input  wire logic [FIELD_W-1:0]  item_value_i,
  input  wire logic [ID_W-1:0]     entry_id_i,
  output logic                     strobe_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [FIELD_W-1:0]       found_key_o,
  output logic [FIELD_W-1:0]       found_value_o,
  output logic [FID_W-1:0]         found_id_o,
  output logic [TOTAL_W-1:0]       entry_total_o
);

  fsm_e                   state_q, state_d;
  logic [KIND_W-1:0]      kind_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [ID_W-1:0]        id_q;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   strobe_q;
  logic [STATUS_W-1:0]    status_q, status_d;
  logic [FIELD_W-1:0]     fkey_q, fkey_d, fval_q, fval_d;
  logic [FID_W-1:0]       fid_q, fid_d;
  logic [TOTAL_W-1:0]     total_q;
  logic                   accept, exec, found, in_range;
  cell_ctrl_t             ctrl;

  logic [KEY_WIDTH-1:0]   cell_key   [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic                   hit_c      [CAPACITY+1];
  logic [IDX_W-1:0]       pos_c      [CAPACITY+1];
  logic [KEY_WIDTH-1:0]   rdk_c      [CAPACITY+1];
  logic [VALUE_WIDTH-1:0] rdv_c      [CAPACITY+1];

  assign accept = start && (state_q == FSM_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept) state_d = FSM_EXEC;
      end
      FSM_EXEC: state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    case (state_q)
      FSM_IDLE: busy = 1'b0;
      FSM_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default:  busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      key_q   <= KEY_WIDTH'(item_key_i);
      value_q <= VALUE_WIDTH'(item_value_i);
      id_q    <= entry_id_i;
    end
    if (exec) begin
      status_q <= status_d;
      fkey_q   <= fkey_d;
      fval_q   <= fval_d;
      fid_q    <= fid_d;
      total_q  <= TOTAL_W'(count_d);
    end
  end

  always_comb begin
    ctrl.active = exec;
    ctrl.kind   = kind_q;
    ctrl.key    = key_q;
    ctrl.value  = value_q;
    ctrl.id     = id_q;
    ctrl.count  = count_q;
  end

  assign hit_c[0] = 1'b0;
  assign pos_c[0] = '0;
  assign rdk_c[0] = '0;
  assign rdv_c[0] = '0;
  assign found    = hit_c[CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0]   nb_key;
    logic [VALUE_WIDTH-1:0] nb_value;
    if (i < CAPACITY - 1) begin : g_mid
      assign nb_key   = cell_key[i+1];
      assign nb_value = cell_value[i+1];
    end else begin : g_last
      assign nb_key   = '0;
      assign nb_value = '0;
    end
    kvt_cell u_cell (
      .clk_i      (clk_i),
      .idx_i      (IDX_W'(i)),
      .ctrl_i     (ctrl),
      .found_i    (found),
      .nb_key_i   (nb_key),
      .nb_value_i (nb_value),
      .hit_i      (hit_c[i]),
      .pos_i      (pos_c[i]),
      .rd_key_i   (rdk_c[i]),
      .rd_value_i (rdv_c[i]),
      .key_o      (cell_key[i]),
      .value_o    (cell_value[i]),
      .hit_o      (hit_c[i+1]),
      .pos_o      (pos_c[i+1]),
      .rd_key_o   (rdk_c[i+1]),
      .rd_value_o (rdv_c[i+1])
    );
  end

  always_comb begin
    in_range = CMP_W'(id_q) < CMP_W'(count_q);
    status_d = STAT_OK;
    fkey_d   = '0;
    fval_d   = '0;
    fid_d    = '0;
    count_d  = count_q;
    if (exec) begin
      case (kind_q)
        KIND_ADD: begin
          if (found) begin
            status_d = STAT_DUP;
            fid_d    = FID_W'(pos_c[CAPACITY]);
          end else if (count_q == CNT_W'(CAPACITY)) begin
            status_d = STAT_FULL;
          end else begin
            fid_d   = FID_W'(count_q);
            count_d = count_q + CNT_W'(1);
          end
        end
        KIND_DEL_ID: begin
          if (in_range) begin
            fid_d   = FID_W'(id_q);
            count_d = count_q - CNT_W'(1);
          end else begin
            status_d = STAT_RANGE;
          end
        end
        KIND_DEL_KEY: begin
          if (found) begin
            fid_d   = FID_W'(pos_c[CAPACITY]);
            count_d = count_q - CNT_W'(1);
          end else begin
            status_d = STAT_NOKEY;
          end
        end
        KIND_GET_KEY: begin
          if (found) begin
            fkey_d = FIELD_W'(rdk_c[CAPACITY]);
            fval_d = FIELD_W'(rdv_c[CAPACITY]);
            fid_d  = FID_W'(pos_c[CAPACITY]);
          end else begin
            status_d = STAT_NOKEY;
          end
        end
        KIND_GET_ID: begin
          if (in_range) begin
            fkey_d = FIELD_W'(rdk_c[CAPACITY]);
            fval_d = FIELD_W'(rdv_c[CAPACITY]);
            fid_d  = FID_W'(id_q);
          end else begin
            status_d = STAT_RANGE;
          end
        end
        default: status_d = STAT_OK;
      endcase
    end
  end

  assign strobe_o      = strobe_q;
  assign status_o      = status_q;
  assign found_key_o   = fkey_q;
  assign found_value_o = fval_q;
  assign found_id_o    = fid_q;
  assign entry_total_o = total_q;

endmodule

`default_nettype wire

// ===== src/kvt_cell.sv =====
// One table cell: holds one key/value entry, compares it, writes it on an add and shifts it toward the front.
`default_nettype none

module kvt_cell
  import kvt_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic [IDX_W-1:0]       idx_i,
  input  wire cell_ctrl_t             ctrl_i,
  input  wire logic                   found_i,
  input  wire logic [KEY_WIDTH-1:0]   nb_key_i,
  input  wire logic [VALUE_WIDTH-1:0] nb_value_i,
  input  wire logic                   hit_i,
  input  wire logic [IDX_W-1:0]       pos_i,
  input  wire logic [KEY_WIDTH-1:0]   rd_key_i,
  input  wire logic [VALUE_WIDTH-1:0] rd_value_i,
  output logic [KEY_WIDTH-1:0]        key_o,
  output logic [VALUE_WIDTH-1:0]      value_o,
  output logic                        hit_o,
  output logic [IDX_W-1:0]            pos_o,
  output logic [KEY_WIDTH-1:0]        rd_key_o,
  output logic [VALUE_WIDTH-1:0]      rd_value_o
);

  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic live, hit, first, id_ge, id_eq, in_range, shift, write, sel;

  always_comb begin
    live     = CNT_W'(idx_i) < ctrl_i.count;
    hit      = live && (key_q == ctrl_i.key);
    first    = hit && !hit_i;
    id_ge    = CMP_W'(idx_i) >= CMP_W'(ctrl_i.id);
    id_eq    = CMP_W'(idx_i) == CMP_W'(ctrl_i.id);
    in_range = CMP_W'(ctrl_i.id) < CMP_W'(ctrl_i.count);
    shift    = ctrl_i.active &&
               (((ctrl_i.kind == KIND_DEL_ID) && in_range && id_ge) ||
                ((ctrl_i.kind == KIND_DEL_KEY) && (hit_i || hit)));
    write    = ctrl_i.active && (ctrl_i.kind == KIND_ADD) && !found_i &&
               (CNT_W'(idx_i) == ctrl_i.count);
    sel      = ((ctrl_i.kind == KIND_GET_KEY) && first) ||
               ((ctrl_i.kind == KIND_GET_ID) && in_range && id_eq);
  end

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    if (shift) begin
      key_d   = nb_key_i;
      value_d = nb_value_i;
    end else if (write) begin
      key_d   = ctrl_i.key;
      value_d = ctrl_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign key_o      = key_q;
  assign value_o    = value_q;
  assign hit_o      = hit_i | hit;
  assign pos_o      = pos_i | (first ? idx_i : '0);
  assign rd_key_o   = rd_key_i | (sel ? key_q : '0);
  assign rd_value_o = rd_value_i | (sel ? value_q : '0);

endmodule

`default_nettype wire

// ===== src/kvt_checker.sv =====
// Port-level checks of the compacting key/value table and their binding to the top level.
`default_nettype none

module kvt_checker
  import kvt_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                strobe_o,
  input wire logic [STATUS_W-1:0] status_o,
  input wire logic [FIELD_W-1:0]  found_key_o,
  input wire logic [FIELD_W-1:0]  found_value_o
);

  // Every accepted transaction is answered by a result strobe after its busy cycle.
  a_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 strobe_o)
    else $error("accepted transaction not answered two cycles later");

  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy && $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // Failed operations never return entry data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o != STAT_OK) |-> (found_key_o == '0) && (found_value_o == '0))
    else $error("failed operation returned entry data");

endmodule

bind compacting_key_value_table kvt_checker u_kvt_checker (.*);

`default_nettype wire

// ===== sim/compacting_key_value_table_tb.sv =====
// Self-checking testbench for the compacting key/value table with a built-in table predictor.
`timescale 1ns / 100ps

module compacting_key_value_table_tb
  import kvt_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 300;
  localparam int POOL_SIZE = 24;
  localparam int PRINT_CAP = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] value;
    logic [ID_W-1:0]    id;
  } command_t;

  typedef struct {
    status_e            status;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] value;
    logic [FID_W-1:0]   fid;
    logic [TOTAL_W-1:0] total;
  } lookup_t;

  typedef struct {
    command_t cmd;
    bit       typed;
    lookup_t  res;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   kind_i;
  logic [FIELD_W-1:0]  item_key_i;
  logic [FIELD_W-1:0]  item_value_i;
  logic [ID_W-1:0]     entry_id_i;
  logic                strobe_o;
  logic [STATUS_W-1:0] status_o;
  logic [FIELD_W-1:0]  found_key_o;
  logic [FIELD_W-1:0]  found_value_o;
  logic [FID_W-1:0]    found_id_o;
  logic [TOTAL_W-1:0]  entry_total_o;

  logic [FIELD_W-1:0] shadow_keys[CAPACITY];
  logic [FIELD_W-1:0] shadow_values[CAPACITY];
  int                 shadow_count;

  lookup_t            pending_lookups[$];
  stim_row_t          directed_rows[$];
  logic [FIELD_W-1:0] key_pool[POOL_SIZE];
  int                 mismatches;
  int                 cycle_count;
  int                 idle_pct;

  compacting_key_value_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .item_key_i    (item_key_i),
    .item_value_i  (item_value_i),
    .entry_id_i    (entry_id_i),
    .strobe_o      (strobe_o),
    .status_o      (status_o),
    .found_key_o   (found_key_o),
    .found_value_o (found_value_o),
    .found_id_o    (found_id_o),
    .entry_total_o (entry_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("compacting_key_value_table verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input logic [FIELD_W-1:0] got,
                                 input logic [FIELD_W-1:0] want);
    if (mismatches < PRINT_CAP) begin
      $display("%0t: %s mismatch, got %h, expected %h", $time, field, got, want);
    end
    mismatches++;
  endtask

  function automatic int key_position(input logic [FIELD_W-1:0] k);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_keys[i] == k) return i;
    end
    return CAPACITY;
  endfunction

  function automatic void remove_entry(input int pos);
    for (int i = pos; i < shadow_count - 1; i++) begin
      shadow_keys[i] = shadow_keys[i + 1];
      shadow_values[i] = shadow_values[i + 1];
    end
    shadow_count--;
  endfunction

  function automatic lookup_t apply_command(input command_t c);
    lookup_t r;
    int pos;
    r.status = STAT_OK;
    r.key = '0;
    r.value = '0;
    r.fid = '0;
    case (c.kind)
      KIND_ADD: begin
        pos = key_position(c.key);
        if (pos < CAPACITY) begin
          r.status = STAT_DUP;
          r.fid = FID_W'(pos);
        end else if (shadow_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          shadow_keys[shadow_count] = c.key;
          shadow_values[shadow_count] = c.value;
          r.fid = FID_W'(shadow_count);
          shadow_count++;
        end
      end
      KIND_DEL_ID: begin
        if (int'(c.id) >= shadow_count) begin
          r.status = STAT_RANGE;
        end else begin
          remove_entry(int'(c.id));
          r.fid = c.id;
        end
      end
      KIND_DEL_KEY: begin
        pos = key_position(c.key);
        if (pos >= CAPACITY) begin
          r.status = STAT_NOKEY;
        end else begin
          remove_entry(pos);
          r.fid = FID_W'(pos);
        end
      end
      KIND_GET_KEY: begin
        pos = key_position(c.key);
        if (pos >= CAPACITY) begin
          r.status = STAT_NOKEY;
        end else begin
          r.key = shadow_keys[pos];
          r.value = shadow_values[pos];
          r.fid = FID_W'(pos);
        end
      end
      KIND_GET_ID: begin
        if (int'(c.id) >= shadow_count) begin
          r.status = STAT_RANGE;
        end else begin
          r.key = shadow_keys[c.id];
          r.value = shadow_values[c.id];
          r.fid = c.id;
        end
      end
      default: begin
      end
    endcase
    r.total = TOTAL_W'(shadow_count);
    return r;
  endfunction

  function automatic stim_row_t stim_row(input logic [KIND_W-1:0] kind,
                                         input logic [FIELD_W-1:0] key,
                                         input logic [FIELD_W-1:0] value,
                                         input logic [ID_W-1:0] id, input bit typed,
                                         input status_e status,
                                         input logic [FIELD_W-1:0] fkey,
                                         input logic [FIELD_W-1:0] fvalue,
                                         input logic [FID_W-1:0] fid,
                                         input logic [TOTAL_W-1:0] total);
    stim_row_t s;
    s.cmd.kind = kind;
    s.cmd.key = key;
    s.cmd.value = value;
    s.cmd.id = id;
    s.typed = typed;
    s.res.status = status;
    s.res.key = fkey;
    s.res.value = fvalue;
    s.res.fid = fid;
    s.res.total = total;
    return s;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  task automatic issue(input command_t c, input lookup_t r);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    kind_i <= c.kind;
    item_key_i <= c.key;
    item_value_i <= c.value;
    entry_id_i <= c.id;
    while (busy !== 1'b0) @(negedge clk_i);
    pending_lookups.push_back(r);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    lookup_t e;
    if (rst_ni === 1'b1 && strobe_o === 1'b1) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("unexpected transaction", found_key_o, '0);
      end else begin
        e = pending_lookups.pop_front();
        if (status_o !== e.status) begin
          report_mismatch("status", FIELD_W'(status_o), FIELD_W'(e.status));
        end
        if (found_key_o !== e.key) report_mismatch("found_key", found_key_o, e.key);
        if (found_value_o !== e.value) report_mismatch("found_value", found_value_o, e.value);
        if (found_id_o !== e.fid) begin
          report_mismatch("found_id", FIELD_W'(found_id_o), FIELD_W'(e.fid));
        end
        if (entry_total_o !== e.total) begin
          report_mismatch("entry_total", FIELD_W'(entry_total_o), FIELD_W'(e.total));
        end
      end
    end else if (rst_ni === 1'b1 && strobe_o !== 1'b0) begin
      report_mismatch("strobe", FIELD_W'(strobe_o), '0);
    end
  end

  initial begin
    command_t  c;
    lookup_t   r;
    stim_row_t s;
    int        w;
    int        add_pct;
    int        phase_idle[4];
    int        phase_add[4];

    start = 1'b0;
    kind_i = KIND_ADD;
    item_key_i = '0;
    item_value_i = '0;
    entry_id_i = '0;
    rst_ni = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    idle_pct = 0;
    shadow_count = 0;
    phase_idle = '{0, 49, 0, 9};
    phase_add = '{40, 25, 45, 30};

    directed_rows.push_back(stim_row(KIND_GET_ID, '0, '0, 4'd0, 1, STAT_RANGE, '0, '0, 4'd0, 5'd0));
    directed_rows.push_back(stim_row(KIND_GET_KEY, '0, '0, 4'd0, 1, STAT_NOKEY, '0, '0, 4'd0, 5'd0));
    directed_rows.push_back(stim_row(KIND_DEL_ID, '0, '0, 4'd15, 1, STAT_RANGE, '0, '0, 4'd0, 5'd0));
    directed_rows.push_back(stim_row(KIND_DEL_KEY, '1, '0, 4'd0, 1, STAT_NOKEY, '0, '0, 4'd0, 5'd0));
    directed_rows.push_back(stim_row(KIND_ADD, '0, '1, 4'd0, 1, STAT_OK, '0, '0, 4'd0, 5'd1));
    directed_rows.push_back(stim_row(KIND_ADD, '1, '0, 4'd0, 1, STAT_OK, '0, '0, 4'd1, 5'd2));
    directed_rows.push_back(stim_row(KIND_ADD, '0, 32'h5A5A_5A5A, 4'd0, 1, STAT_DUP,
                                     '0, '0, 4'd0, 5'd2));
    directed_rows.push_back(stim_row(KIND_RSVD_LO, '1, '1, 4'd15, 1, STAT_OK,
                                     '0, '0, 4'd0, 5'd2));
    directed_rows.push_back(stim_row(KIND_RSVD_HI, '1, '1, 4'd15, 1, STAT_OK,
                                     '0, '0, 4'd0, 5'd2));
    directed_rows.push_back(stim_row(KIND_GET_KEY, '1, '0, 4'd0, 1, STAT_OK, '1, '0, 4'd1, 5'd2));
    directed_rows.push_back(stim_row(KIND_GET_ID, '0, '0, 4'd0, 1, STAT_OK, '0, '1, 4'd0, 5'd2));
    for (int i = 2; i < CAPACITY; i++) begin
      directed_rows.push_back(stim_row(KIND_ADD, 32'hA5A5_0000 | i, ~(32'hA5A5_0000 | i),
                                       4'd0, 0, STAT_OK, '0, '0, 4'd0, 5'd0));
    end
    directed_rows.push_back(stim_row(KIND_ADD, 32'h0000_1234, '1, 4'd0, 1, STAT_FULL,
                                     '0, '0, 4'd0, 5'd16));
    directed_rows.push_back(stim_row(KIND_ADD, '1, '1, 4'd0, 1, STAT_DUP, '0, '0, 4'd1, 5'd16));
    directed_rows.push_back(stim_row(KIND_GET_ID, '0, '0, 4'd15, 0, STAT_OK, '0, '0, 4'd0, 5'd0));
    directed_rows.push_back(stim_row(KIND_DEL_ID, '0, '0, 4'd15, 1, STAT_OK, '0, '0, 4'd15, 5'd15));
    directed_rows.push_back(stim_row(KIND_GET_ID, '0, '0, 4'd15, 1, STAT_RANGE,
                                     '0, '0, 4'd0, 5'd15));
    directed_rows.push_back(stim_row(KIND_DEL_KEY, '0, '0, 4'd0, 1, STAT_OK, '0, '0, 4'd0, 5'd14));
    directed_rows.push_back(stim_row(KIND_GET_ID, '0, '0, 4'd0, 1, STAT_OK, '1, '0, 4'd0, 5'd14));
    directed_rows.push_back(stim_row(KIND_DEL_KEY, '0, '0, 4'd0, 1, STAT_NOKEY,
                                     '0, '0, 4'd0, 5'd14));
    directed_rows.push_back(stim_row(KIND_GET_KEY, 32'hA5A5_0005, '0, 4'd0, 0, STAT_OK,
                                     '0, '0, 4'd0, 5'd0));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      s = directed_rows[i];
      r = apply_command(s.cmd);
      if (s.typed) r = s.res;
      issue(s.cmd, r);
    end

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      add_pct = phase_add[p];
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int k = 2; k < POOL_SIZE; k++) key_pool[k] = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        w = $urandom_range(99);
        if (w < 4) begin
          c.kind = KIND_W'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
        end else if (w < 4 + add_pct) begin
          c.kind = KIND_ADD;
        end else begin
          case ($urandom_range(3))
            0: c.kind = KIND_DEL_ID;
            1: c.kind = KIND_DEL_KEY;
            2: c.kind = KIND_GET_KEY;
            default: c.kind = KIND_GET_ID;
          endcase
        end
        if ($urandom_range(99) < 80) c.key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else c.key = $urandom;
        c.value = $urandom;
        if (shadow_count > 0 && $urandom_range(99) < 70) begin
          c.id = ID_W'($urandom_range(shadow_count - 1));
        end else begin
          c.id = ID_W'($urandom_range(15));
        end
        r = apply_command(c);
        issue(c, r);
      end
    end

    start <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("compacting_key_value_table verification clean");
    end else begin
      $display("compacting_key_value_table verification failed");
    end
    $finish;
  end

endmodule
